// ===== sv/s2i_pkg.sv =====
// Package for the string-to-signed-integer parser: character codes, parse
// phases, result record and the digit decoder.
// No dependencies; every other file of the block uses it.
`default_nettype none

package s2i_pkg;

    localparam int POSITION_BITS_DEF = 16;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A_UP   = 8'h41;
    localparam logic [7:0] CH_Z_UP   = 8'h5A;
    localparam logic [7:0] CH_A_LO   = 8'h61;
    localparam logic [7:0] CH_Z_LO   = 8'h7A;
    localparam logic [7:0] CH_X_UP   = 8'h58;
    localparam logic [7:0] CH_X_LO   = 8'h78;
    // Offsets that map letters onto digit values 10..35.
    localparam logic [7:0] UP_BIAS   = 8'h37;
    localparam logic [7:0] LO_BIAS   = 8'h57;

    localparam logic [5:0] NOT_A_DIGIT = 6'd36;
    localparam logic [5:0] RADIX_AUTO  = 6'd0;
    localparam logic [5:0] RADIX_OCT   = 6'd8;
    localparam logic [5:0] RADIX_DEC   = 6'd10;
    localparam logic [5:0] RADIX_HEX   = 6'd16;
    localparam logic [5:0] RADIX_RESET = 6'd10;

    localparam logic [63:0] LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIM_NEG = 64'h8000_0000_0000_0000;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_LEAD     = 3'd1,
        PH_SIGNED   = 3'd2,
        PH_ZERO     = 3'd3,
        PH_HEXFIRST = 3'd4,
        PH_DIGITS   = 3'd5,
        PH_DONE     = 3'd6
    } phase_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic [15:0]        end_offset;
        logic               converted;
        logic               saturated;
    } result_t;

    function automatic logic [5:0] digit_of(input logic [7:0] ch);
        logic [5:0] dv;
        dv = NOT_A_DIGIT;
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
            dv = 6'(ch - CH_ZERO);
        end else if (ch >= CH_A_UP && ch <= CH_Z_UP) begin
            dv = 6'(ch - UP_BIAS);
        end else if (ch >= CH_A_LO && ch <= CH_Z_LO) begin
            dv = 6'(ch - LO_BIAS);
        end
        return dv;
    endfunction

endpackage

`default_nettype wire

// ===== sv/s2i_mac.sv =====
// Accumulator step for the parser: acc * radix + digit with a range check
// against the signed 64-bit limit of the current sign. Uses s2i_pkg.
`default_nettype none

module s2i_mac (
    input  wire logic [63:0] acc,
    input  wire logic [5:0]  radix,
    input  wire logic [5:0]  digit,
    input  wire logic        negative,
    output logic      [63:0] sum,
    output logic             overflow
);

    logic [69:0] prod;
    logic [70:0] total;
    logic [63:0] lim;

    always_comb begin
        lim      = negative ? s2i_pkg::LIM_NEG : s2i_pkg::LIM_POS;
        prod     = 70'(acc) * 70'(radix);
        total    = 71'(prod) + 71'(digit);
        sum      = total[63:0];
        // The parser uses the flag only for a digit below the radix, and then
        // this matches the quotient and remainder test against the limit.
        overflow = total > 71'(lim);
    end

endmodule

`default_nettype wire

// ===== sv/s2i_parse.sv =====
// Parse state machine of the string-to-signed-integer parser: phase, sign, radix,
// accumulator, overflow, digit-seen and position registers, one character per transfer.
// Uses s2i_pkg and s2i_mac.
`default_nettype none

module s2i_parse #(
    parameter int POSITION_BITS = s2i_pkg::POSITION_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_fire,
    input  wire logic [7:0]        char_in,
    input  wire logic              string_start,
    input  wire logic [5:0]        radix_cfg,
    output logic                   res_push,
    output s2i_pkg::result_t       res
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};

    s2i_pkg::phase_t           phase_reg, phase_next, ph_e;
    logic                      neg_reg, neg_next, neg_e;
    logic [5:0]                ar_reg, ar_next, ar_e;
    logic [63:0]               acc_reg, acc_next, acc_e;
    logic                      ovf_reg, ovf_next, ovf_e;
    logic                      ds_reg, ds_next, ds_e;
    logic [POSITION_BITS-1:0]  pos_reg, pos_next, pos_e;

    logic [5:0]  dv;
    logic [5:0]  ar_first, ar_zero, mac_r;
    logic        zero_pref, is_x, active;
    logic        take, emit, neg_set, load_x, ds_force, zero_base, use_xpos;
    logic [63:0] mac_base, mac_sum;
    logic        mac_ovf;
    logic        ds_o;
    logic [63:0] val_o;
    logic [POSITION_BITS-1:0] end_pos;

    // A start flag restarts the parse with this very character.
    always_comb begin
        ph_e  = string_start ? s2i_pkg::PH_LEAD : phase_reg;
        neg_e = string_start ? 1'b0 : neg_reg;
        ar_e  = string_start ? radix_cfg : ar_reg;
        acc_e = string_start ? 64'd0 : acc_reg;
        ovf_e = string_start ? 1'b0 : ovf_reg;
        ds_e  = string_start ? 1'b0 : ds_reg;
        pos_e = string_start ? '0 : pos_reg;
    end

    always_comb begin
        dv        = s2i_pkg::digit_of(char_in);
        zero_pref = (char_in == s2i_pkg::CH_ZERO) &&
                    (ar_e == s2i_pkg::RADIX_AUTO || ar_e == s2i_pkg::RADIX_HEX);
        is_x      = (char_in == s2i_pkg::CH_X_LO) || (char_in == s2i_pkg::CH_X_UP);
        ar_first  = (ar_e == s2i_pkg::RADIX_AUTO) ? s2i_pkg::RADIX_DEC : ar_e;
        ar_zero   = (ar_e == s2i_pkg::RADIX_AUTO) ? s2i_pkg::RADIX_OCT : ar_e;
        active    = (ph_e != s2i_pkg::PH_IDLE) && (ph_e != s2i_pkg::PH_DONE);
    end

    // Next phase and step decisions.
    always_comb begin
        phase_next = ph_e;
        ar_next    = ar_e;
        mac_r      = ar_e;
        take       = 1'b0;
        emit       = 1'b0;
        neg_set    = 1'b0;
        load_x     = 1'b0;
        ds_force   = 1'b0;
        zero_base  = 1'b0;
        use_xpos   = 1'b0;
        unique case (ph_e)
            s2i_pkg::PH_LEAD, s2i_pkg::PH_SIGNED: begin
                priority if (ph_e == s2i_pkg::PH_LEAD && char_in == s2i_pkg::CH_SPACE) begin
                    phase_next = ph_e;
                end else if (ph_e == s2i_pkg::PH_LEAD && char_in == s2i_pkg::CH_MINUS) begin
                    neg_set    = 1'b1;
                    phase_next = s2i_pkg::PH_SIGNED;
                end else if (ph_e == s2i_pkg::PH_LEAD && char_in == s2i_pkg::CH_PLUS) begin
                    phase_next = s2i_pkg::PH_SIGNED;
                end else if (zero_pref) begin
                    phase_next = s2i_pkg::PH_ZERO;
                end else begin
                    ar_next = ar_first;
                    mac_r   = ar_first;
                    if (dv < ar_first) begin
                        take       = 1'b1;
                        phase_next = s2i_pkg::PH_DIGITS;
                    end else begin
                        emit       = 1'b1;
                        phase_next = s2i_pkg::PH_DONE;
                    end
                end
            end
            s2i_pkg::PH_ZERO: begin
                if (is_x) begin
                    ar_next    = s2i_pkg::RADIX_HEX;
                    load_x     = 1'b1;
                    phase_next = s2i_pkg::PH_HEXFIRST;
                end else begin
                    // The leading zero counts as a converted digit.
                    ar_next  = ar_zero;
                    mac_r    = ar_zero;
                    ds_force = 1'b1;
                    if (dv < ar_zero) begin
                        take       = 1'b1;
                        phase_next = s2i_pkg::PH_DIGITS;
                    end else begin
                        emit       = 1'b1;
                        phase_next = s2i_pkg::PH_DONE;
                    end
                end
            end
            s2i_pkg::PH_HEXFIRST: begin
                // A lone prefix falls back to the zero, ending at the 'x'.
                zero_base = 1'b1;
                ds_force  = 1'b1;
                mac_r     = s2i_pkg::RADIX_HEX;
                if (dv < s2i_pkg::RADIX_HEX) begin
                    take       = 1'b1;
                    phase_next = s2i_pkg::PH_DIGITS;
                end else begin
                    emit       = 1'b1;
                    use_xpos   = 1'b1;
                    phase_next = s2i_pkg::PH_DONE;
                end
            end
            s2i_pkg::PH_DIGITS: begin
                if (dv < ar_e) begin
                    take       = 1'b1;
                    phase_next = s2i_pkg::PH_DIGITS;
                end else begin
                    emit       = 1'b1;
                    phase_next = s2i_pkg::PH_DONE;
                end
            end
            default: begin
                phase_next = ph_e;
            end
        endcase
    end

    assign mac_base = zero_base ? 64'd0 : acc_e;

    s2i_mac u_mac (
        .acc      (mac_base),
        .radix    (mac_r),
        .digit    (dv),
        .negative (neg_e),
        .sum      (mac_sum),
        .overflow (mac_ovf)
    );

    // Datapath next values.
    always_comb begin
        neg_next = neg_e | neg_set;
        acc_next = mac_base;
        ovf_next = ovf_e;
        ds_next  = ds_e | ds_force;
        if (load_x) begin
            acc_next = 64'(pos_e);
        end
        if (take) begin
            ds_next = 1'b1;
            if (ovf_e || mac_ovf) begin
                ovf_next = 1'b1;
            end else begin
                acc_next = mac_sum;
            end
        end
        if (active && pos_e != POS_MAX) begin
            pos_next = pos_e + POS_ONE;
        end else begin
            pos_next = pos_e;
        end
    end

    // Result of a terminating character.
    always_comb begin
        ds_o    = ds_e | ds_force;
        end_pos = use_xpos ? acc_e[POSITION_BITS-1:0] : pos_e;
        if (!ds_o) begin
            val_o = 64'd0;
        end else if (ovf_e) begin
            val_o = neg_e ? s2i_pkg::LIM_NEG : s2i_pkg::LIM_POS;
        end else begin
            val_o = neg_e ? (64'd0 - mac_base) : mac_base;
        end
        res.value      = $signed(val_o);
        res.end_offset = ds_o ? 16'(end_pos) : 16'd0;
        res.converted  = ds_o;
        res.saturated  = ds_o & ovf_e;
        res_push       = in_fire & emit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= s2i_pkg::PH_IDLE;
            neg_reg   <= 1'b0;
            ar_reg    <= 6'd0;
            acc_reg   <= 64'd0;
            ovf_reg   <= 1'b0;
            ds_reg    <= 1'b0;
            pos_reg   <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            ar_reg    <= ar_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            ds_reg    <= ds_next;
            pos_reg   <= pos_next;
        end
    end

`ifndef SYNTH
    a_take_xor_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(take && emit))
        else $error("digit taken and number ended on the same character");

    a_done_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |=> phase_reg == s2i_pkg::PH_DONE)
        else $error("parser not finished after emitting a result");

    a_quiet_outside: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && !string_start &&
        (phase_reg == s2i_pkg::PH_IDLE || phase_reg == s2i_pkg::PH_DONE) |-> !res_push)
        else $error("result emitted outside a string");

    a_sat_needs_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> (!res.saturated || res.converted))
        else $error("saturated result without a converted digit");
`endif

endmodule

`default_nettype wire

// ===== sv/s2i_out_buf.sv =====
// Result register of the parser: holds one result until its transfer on
// the output channel. Uses s2i_pkg for the result record.
`default_nettype none

module s2i_out_buf (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire s2i_pkg::result_t res_in,
    output logic                  can_take,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output s2i_pkg::result_t      res_out
);

    logic             valid_reg, valid_next;
    s2i_pkg::result_t res_reg;

    // The slot is free when empty or when its result leaves this cycle.
    assign can_take = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign res_out  = res_reg;

    always_comb begin
        if (push) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            res_reg <= res_in;
        end
    end

endmodule

`default_nettype wire

// ===== sv/string_to_signed_integer_parser_core.sv =====
// Streaming string-to-signed-64-bit-integer parser, one character per transfer.
// Throughput: one character per cycle, set by the combinational multiply-add and
// limit compare; s_ready drops only while a result is held and m_ready is low.
// A result appears on m_valid in the cycle after the transfer of the character
// that ends the number. Reset (aresetn low, synchronous) idles the parser,
// empties the result register and sets the radix register to 10.
`default_nettype none

module string_to_signed_integer_parser_core #(
    parameter int POSITION_BITS = s2i_pkg::POSITION_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [5:0]         cfg_radix,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_char_in,
    input  wire logic               s_string_start,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [63:0]      m_value,
    output logic [15:0]             m_end_offset,
    output logic                    m_converted,
    output logic                    m_saturated
);

    logic             cfg_fire;
    logic [5:0]       radix_reg, radix_next;
    logic             in_fire;
    logic             res_push;
    s2i_pkg::result_t res_step, res_held;

    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid & cfg_ready;
    assign radix_next = cfg_radix;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= s2i_pkg::RADIX_RESET;
        end else if (cfg_fire) begin
            radix_reg <= radix_next;
        end
    end

    assign in_fire = s_valid & s_ready;

    s2i_parse #(
        .POSITION_BITS (POSITION_BITS)
    ) u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_fire      (in_fire),
        .char_in      (s_char_in),
        .string_start (s_string_start),
        .radix_cfg    (radix_reg),
        .res_push     (res_push),
        .res          (res_step)
    );

    s2i_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (res_push),
        .res_in   (res_step),
        .can_take (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .res_out  (res_held)
    );

    assign m_value      = res_held.value;
    assign m_end_offset = res_held.end_offset;
    assign m_converted  = res_held.converted;
    assign m_saturated  = res_held.saturated;

endmodule

`default_nettype wire

// ===== tb/parse_result_checker.sv =====
// Checker for the string-to-integer parser: predicts each number from the
// accepted characters and compares it with the result channel.
// Depends on s2i_pkg for the character codes, radix codes and phase type.
module parse_result_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [5:0]         cfg_radix,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_char_in,
    input  logic               s_string_start,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [63:0] m_value,
    input  logic [15:0]        m_end_offset,
    input  logic               m_converted,
    input  logic               m_saturated,
    output int                 mismatch_total,
    output int                 pending_results
);

    localparam logic [15:0] OFFSET_MAX = 16'hFFFF;

    logic [5:0]      radix_reg;
    s2i_pkg::phase_t phase;
    logic            negative;
    logic [5:0]      active_radix;
    logic [63:0]     acc;
    logic            overflowed;
    logic            digit_taken;
    logic [15:0]     offset;
    int              failures;

    s2i_pkg::result_t expected_numbers[$];

    function automatic logic [5:0] char_value(input logic [7:0] ch);
        if (ch >= s2i_pkg::CH_ZERO && ch <= s2i_pkg::CH_NINE) begin
            return 6'(ch - s2i_pkg::CH_ZERO);
        end
        if (ch >= s2i_pkg::CH_A_UP && ch <= s2i_pkg::CH_Z_UP) begin
            return 6'(int'(ch) - int'(s2i_pkg::CH_A_UP) + 10);
        end
        if (ch >= s2i_pkg::CH_A_LO && ch <= s2i_pkg::CH_Z_LO) begin
            return 6'(int'(ch) - int'(s2i_pkg::CH_A_LO) + 10);
        end
        return s2i_pkg::NOT_A_DIGIT;
    endfunction

    // Once the value would pass the signed limit it is frozen and only the
    // overflow flag moves.
    task automatic take_digit(input logic [5:0] dv);
        logic [63:0] lim;
        logic [63:0] base;
        logic [63:0] quot;
        logic [63:0] rem;
        lim  = negative ? s2i_pkg::LIM_NEG : s2i_pkg::LIM_POS;
        base = {58'd0, active_radix};
        quot = lim / base;
        rem  = lim % base;
        digit_taken = 1'b1;
        if (overflowed || acc > quot || (acc == quot && {58'd0, dv} > rem)) begin
            overflowed = 1'b1;
        end else begin
            acc = acc * base + {58'd0, dv};
        end
    endtask

    task automatic close_number(input logic [15:0] end_at, output s2i_pkg::result_t res);
        res = '0;
        if (digit_taken) begin
            if (overflowed) begin
                res.value = negative ? s2i_pkg::LIM_NEG : s2i_pkg::LIM_POS;
            end else begin
                res.value = negative ? (64'd0 - acc) : acc;
            end
            res.end_offset = end_at;
            res.converted  = 1'b1;
            res.saturated  = overflowed;
        end
        phase = s2i_pkg::PH_DONE;
    endtask

    task automatic digit_or_end(input logic [7:0] ch, input logic [15:0] here,
                                inout bit produced, inout s2i_pkg::result_t res);
        logic [5:0] dv;
        dv = char_value(ch);
        if (dv < active_radix) begin
            take_digit(dv);
            phase = s2i_pkg::PH_DIGITS;
        end else begin
            close_number(here, res);
            produced = 1'b1;
        end
    endtask

    task automatic first_digit(input logic [7:0] ch, input logic [15:0] here,
                               inout bit produced, inout s2i_pkg::result_t res);
        if (ch == s2i_pkg::CH_ZERO &&
            (active_radix == s2i_pkg::RADIX_AUTO || active_radix == s2i_pkg::RADIX_HEX)) begin
            phase = s2i_pkg::PH_ZERO;
        end else begin
            if (active_radix == s2i_pkg::RADIX_AUTO) active_radix = s2i_pkg::RADIX_DEC;
            digit_or_end(ch, here, produced, res);
        end
    endtask

    task automatic advance_parse(input logic [7:0] ch, input logic start,
                                 output bit produced, output s2i_pkg::result_t res);
        logic [5:0]  dv;
        logic [15:0] here;
        logic [15:0] x_at;
        produced = 1'b0;
        res      = '0;
        if (start) begin
            phase        = s2i_pkg::PH_LEAD;
            negative     = 1'b0;
            active_radix = radix_reg;
            acc          = '0;
            overflowed   = 1'b0;
            digit_taken  = 1'b0;
            offset       = '0;
        end
        if (phase != s2i_pkg::PH_IDLE && phase != s2i_pkg::PH_DONE) begin
            here = offset;
            case (phase)
                s2i_pkg::PH_LEAD: begin
                    if (ch == s2i_pkg::CH_MINUS) begin
                        negative = 1'b1;
                        phase    = s2i_pkg::PH_SIGNED;
                    end else if (ch == s2i_pkg::CH_PLUS) begin
                        phase = s2i_pkg::PH_SIGNED;
                    end else if (ch != s2i_pkg::CH_SPACE) begin
                        first_digit(ch, here, produced, res);
                    end
                end
                s2i_pkg::PH_SIGNED: first_digit(ch, here, produced, res);
                s2i_pkg::PH_ZERO: begin
                    if (ch == s2i_pkg::CH_X_LO || ch == s2i_pkg::CH_X_UP) begin
                        // The accumulator parks the offset of the 'x' until the
                        // next character shows whether a hex digit follows.
                        active_radix = s2i_pkg::RADIX_HEX;
                        acc          = {48'd0, here};
                        phase        = s2i_pkg::PH_HEXFIRST;
                    end else begin
                        if (active_radix == s2i_pkg::RADIX_AUTO) begin
                            active_radix = s2i_pkg::RADIX_OCT;
                        end
                        take_digit(6'd0);
                        digit_or_end(ch, here, produced, res);
                    end
                end
                s2i_pkg::PH_HEXFIRST: begin
                    dv   = char_value(ch);
                    x_at = acc[15:0];
                    acc  = '0;
                    if (dv < s2i_pkg::RADIX_HEX) begin
                        take_digit(dv);
                        phase = s2i_pkg::PH_DIGITS;
                    end else begin
                        // A lone prefix: the number is the leading zero alone.
                        digit_taken = 1'b1;
                        close_number(x_at, res);
                        produced = 1'b1;
                    end
                end
                s2i_pkg::PH_DIGITS: digit_or_end(ch, here, produced, res);
                default: phase = s2i_pkg::PH_IDLE;
            endcase
            if (offset != OFFSET_MAX) offset = offset + 16'd1;
        end
    endtask

    always @(posedge aclk) begin : watch
        bit               produced;
        s2i_pkg::result_t want;
        s2i_pkg::result_t got;
        if (!aresetn) begin
            radix_reg    = s2i_pkg::RADIX_RESET;
            phase        = s2i_pkg::PH_IDLE;
            negative     = 1'b0;
            active_radix = '0;
            acc          = '0;
            overflowed   = 1'b0;
            digit_taken  = 1'b0;
            offset       = '0;
            expected_numbers.delete();
        end else begin
            if (cfg_valid && cfg_ready) radix_reg = cfg_radix;
            if (s_valid && s_ready) begin
                advance_parse(s_char_in, s_string_start, produced, want);
                if (produced) expected_numbers.push_back(want);
            end
            if (m_valid && m_ready) begin
                got.value      = m_value;
                got.end_offset = m_end_offset;
                got.converted  = m_converted;
                got.saturated  = m_saturated;
                if (expected_numbers.size() == 0) begin
                    if (failures < 10) begin
                        $display("unexpected result transfer: value %0d end %0d conv %0b sat %0b",
                                 $signed(got.value), got.end_offset, got.converted,
                                 got.saturated);
                    end
                    failures++;
                end else begin
                    want = expected_numbers.pop_front();
                    if (got.value !== want.value || got.end_offset !== want.end_offset ||
                        got.converted !== want.converted ||
                        got.saturated !== want.saturated) begin
                        if (failures < 10) begin
                            $display("result mismatch: expected value %0d end %0d conv %0b sat %0b",
                                     $signed(want.value), want.end_offset, want.converted,
                                     want.saturated);
                            $display("                 actual   value %0d end %0d conv %0b sat %0b",
                                     $signed(got.value), got.end_offset, got.converted,
                                     got.saturated);
                        end
                        failures++;
                    end
                end
            end
        end
        mismatch_total  <= failures;
        pending_results <= expected_numbers.size();
    end

endmodule

// ===== tb/tb_string_to_signed_integer_parser_core.sv =====
// Top of the parser testbench: clock, reset, character and radix stimulus,
// result back-pressure and the verdict.
// Depends on s2i_pkg, string_to_signed_integer_parser_core and parse_result_checker.
module tb_string_to_signed_integer_parser_core;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_CHARS = 30;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               cfg_valid      = 1'b0;
    logic [5:0]         cfg_radix      = s2i_pkg::RADIX_RESET;
    logic               s_valid        = 1'b0;
    logic [7:0]         s_char_in      = 8'h00;
    logic               s_string_start = 1'b0;
    logic               m_ready        = 1'b0;
    logic               cfg_ready;
    logic               s_ready;
    logic               m_valid;
    logic signed [63:0] m_value;
    logic [15:0]        m_end_offset;
    logic               m_converted;
    logic               m_saturated;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    bit quiet       = 1'b0;

    logic [5:0] radix_plan [9] = '{6'd0, 6'd16, 6'd2, 6'd36, 6'd1, 6'd63, 6'd37, 6'd8, 6'd10};

    string_to_signed_integer_parser_core DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_radix      (cfg_radix),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_in      (s_char_in),
        .s_string_start (s_string_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_value        (m_value),
        .m_end_offset   (m_end_offset),
        .m_converted    (m_converted),
        .m_saturated    (m_saturated)
    );

    parse_result_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_radix       (cfg_radix),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_in       (s_char_in),
        .s_string_start  (s_string_start),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_value         (m_value),
        .m_end_offset    (m_end_offset),
        .m_converted     (m_converted),
        .m_saturated     (m_saturated),
        .mismatch_total  (mismatches),
        .pending_results (outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_string_to_signed_integer_parser_core: errors");
            $finish;
        end
    end

    // Result side: a fresh stall before every transfer, none while quiet.
    initial begin : result_sink
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Inside this task valid is only lowered when a gap is drawn, so a back-to-back
    // transfer never sees valid fall and rise in one step.
    task automatic push_char(input logic [7:0] ch, input logic start);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_char_in      <= ch;
        s_string_start <= start;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic push_text(input string txt);
        for (int i = 0; i < txt.len(); i++) push_char(txt[i], i == 0);
    endtask

    task automatic push_in_string(input logic [7:0] ch, inout bit first, inout int counted);
        push_char(ch, first);
        first = 1'b0;
        counted++;
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // A fresh string that ends at once leaves the parser finished before the
    // register changes, unless the radix is above 36 and '#' counts as a digit.
    task automatic write_radix(input logic [5:0] radix);
        push_char(8'h23, 1'b1);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_radix <= radix;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [7:0] digit_glyph(input int dv);
        if (dv < 10) return 8'(int'(s2i_pkg::CH_ZERO) + dv);
        if ($urandom_range(0, 1) == 0) return 8'(int'(s2i_pkg::CH_A_UP) + dv - 10);
        return 8'(int'(s2i_pkg::CH_A_LO) + dv - 10);
    endfunction

    task automatic push_random_number(input logic [5:0] radix_cfg, output int counted);
        int spaces;
        int prefix;
        int len;
        int draw_radix;
        int dv;
        bit first;
        counted = 0;
        first   = 1'b1;
        if ($urandom_range(0, 15) == 0) quiet = !quiet;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                counted++;
            end
        end
        spaces = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        repeat (spaces) push_in_string(s2i_pkg::CH_SPACE, first, counted);
        case ($urandom_range(0, 3))
            0: push_in_string(s2i_pkg::CH_MINUS, first, counted);
            1: push_in_string(s2i_pkg::CH_PLUS, first, counted);
            default: ;
        endcase
        prefix = 0;
        if (radix_cfg == s2i_pkg::RADIX_AUTO || radix_cfg == s2i_pkg::RADIX_HEX) begin
            prefix = $urandom_range(0, 3);
        end
        if (prefix == 1 || prefix == 2) begin
            push_in_string(s2i_pkg::CH_ZERO, first, counted);
            push_in_string(prefix == 1 ? s2i_pkg::CH_X_LO : s2i_pkg::CH_X_UP, first, counted);
            draw_radix = 16;
        end else if (prefix == 3) begin
            push_in_string(s2i_pkg::CH_ZERO, first, counted);
            draw_radix = (radix_cfg == s2i_pkg::RADIX_AUTO) ? 8 : 16;
        end else if (radix_cfg == s2i_pkg::RADIX_AUTO) begin
            draw_radix = 10;
        end else begin
            draw_radix = (radix_cfg > 6'd36) ? 36 : int'(radix_cfg);
        end
        // Mostly short numbers, some long enough to saturate in every base from 2 up.
        case ($urandom_range(0, 19))
            0:          len = 0;
            1, 2:       len = $urandom_range(25, 70);
            3, 4, 5, 6: len = $urandom_range(7, 24);
            default:    len = $urandom_range(1, 6);
        endcase
        repeat (len) begin
            dv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 35)
                                             : $urandom_range(0, draw_radix - 1);
            push_in_string(digit_glyph(dv), first, counted);
        end
        // Leaving the terminator out makes the next string cut this one short.
        if ($urandom_range(0, 9) != 0) push_in_string(8'($urandom_range(0, 255)), first, counted);
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 2)) push_char(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    initial begin : stimulus
        int         counted;
        int         phase_chars;
        bit         drained;
        logic [5:0] radix;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, first at the reset radix of ten.
        push_char("Q", 1'b0);
        push_text("  -42#");
        push_text("+x");
        push_text("-");
        push_char(8'h00, 1'b0);
        push_text("9223372036854775807;");
        push_text("-9223372036854775808;");
        push_text("9223372036854775808;");
        push_text("12,");
        push_char("a", 1'b0);
        push_char(8'hFF, 1'b0);
        push_text("55");
        push_text("7 ");
        write_radix(s2i_pkg::RADIX_AUTO);
        push_text("0xz");
        push_text("0X1f!");
        push_text("017 ");
        push_text("0 ");
        push_text("19a");
        write_radix(s2i_pkg::RADIX_HEX);
        push_text("0xg");
        push_text("-0x8000000000000000 ");
        push_text("ff.");

        for (int p = 0; p < 11; p++) begin
            radix = (p < 9) ? radix_plan[p] : 6'($urandom_range(0, 63));
            write_radix(radix);
            phase_chars = 0;
            drained     = 1'b0;
            while (phase_chars < PHASE_CHARS) begin
                if (!drained && phase_chars >= PHASE_CHARS / 2) begin
                    wait_for_results();
                    drained = 1'b1;
                end
                push_random_number(radix, counted);
                phase_chars += counted;
            end
        end

        quiet = 1'b0;
        wait_for_results();
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_string_to_signed_integer_parser_core: clean");
        end else begin
            $display("tb_string_to_signed_integer_parser_core: errors");
        end
        $finish;
    end

endmodule
